/* hw/rtl/mlfd_pkg.sv */
// Package for the learning bridge forwarding decision block.
// Table size, port count, field widths, verdict codes and the lookup result type.
// No dependencies.
`default_nettype none

package mlfd_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int PORT_COUNT    = 24;

  localparam int ADDR_W    = 48;
  localparam int PORT_W    = 5;
  localparam int MASK_W    = 24;
  localparam int VERDICT_W = 2;

  localparam logic [MASK_W-1:0] MASK_RESET = {MASK_W{1'b1}};

  localparam logic [VERDICT_W-1:0] VERDICT_DROP    = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_FORWARD = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_FILTER  = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_FLOOD   = 2'd3;

  // Result of one pass over the address table, against the table as it
  // stood before this item's learning write.
  typedef struct packed {
    logic              src_stored;  // source hit, or a free slot took it
    logic              dst_hit;
    logic [PORT_W-1:0] dst_port;
  } lookup_t;

endpackage

`default_nettype wire

/* hw/rtl/mac_learning_forward_decision.sv */
// Path from input transfer to result valid: input register, then result
// register. Throughput one header per cycle unless out_ready stalls the
// output; table compare and learning write settle between the two registers.
// Reset: synchronous, active high; clears all table valid bits and both stage
// valids, and sets the port enable mask to all ones. No clearing pass needed.
// Top level of the learning bridge forwarding decision.
// Depends on mlfd_pkg and mlfd_table.
`default_nettype none

module mac_learning_forward_decision (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [mlfd_pkg::MASK_W-1:0]       cfg_data,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic [mlfd_pkg::ADDR_W-1:0]       source_address,
  input  wire logic [mlfd_pkg::ADDR_W-1:0]       dest_address,
  input  wire logic [mlfd_pkg::PORT_W-1:0]       arrival_port,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic [mlfd_pkg::VERDICT_W-1:0]    verdict,
  output      logic [mlfd_pkg::PORT_W-1:0]       egress_port,
  output      logic                              learn_failed
);

  logic [mlfd_pkg::MASK_W-1:0]    port_enable_mask;

  logic                           s1_valid;
  logic [mlfd_pkg::ADDR_W-1:0]    s1_src;
  logic [mlfd_pkg::ADDR_W-1:0]    s1_dst;
  logic [mlfd_pkg::PORT_W-1:0]    s1_port;

  logic                           advance;
  logic                           enabled;
  logic                           mask_bit;
  logic [mlfd_pkg::PORT_W-1:0]    mask_idx;
  mlfd_pkg::lookup_t              lookup;

  logic [mlfd_pkg::VERDICT_W-1:0] verdict_next;
  logic [mlfd_pkg::PORT_W-1:0]    egress_next;
  logic                           failed_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_enable_mask <= mlfd_pkg::MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      port_enable_mask <= cfg_data;
    end
  end

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_src  <= source_address;
      s1_dst  <= dest_address;
      s1_port <= arrival_port;
    end
  end

  // Port n maps to mask bit n-1; ports past the mask width count as disabled.
  assign mask_idx = s1_port - mlfd_pkg::PORT_W'(1);

  always_comb begin
    if (s1_port >= mlfd_pkg::PORT_W'(1) && s1_port <= mlfd_pkg::PORT_W'(mlfd_pkg::MASK_W)) begin
      mask_bit = port_enable_mask[mask_idx];
    end else begin
      mask_bit = 1'b0;
    end
  end

  assign enabled = mask_bit && (s1_port <= mlfd_pkg::PORT_W'(mlfd_pkg::PORT_COUNT));

  mlfd_table u_table (
    .clk    (clk),
    .rst    (rst),
    .src    (s1_src),
    .dst    (s1_dst),
    .port   (s1_port),
    .learn  (advance && enabled),
    .lookup (lookup)
  );

  // Learning comes before lookup: a destination equal to a stored source
  // resolves to the arrival port.
  always_comb begin
    verdict_next = mlfd_pkg::VERDICT_DROP;
    egress_next  = '0;
    failed_next  = 1'b0;
    if (enabled) begin
      failed_next = !lookup.src_stored;
      priority if (lookup.src_stored && (s1_dst == s1_src)) begin
        verdict_next = mlfd_pkg::VERDICT_FILTER;
      end else if (!lookup.dst_hit) begin
        verdict_next = mlfd_pkg::VERDICT_FLOOD;
      end else if (lookup.dst_port == s1_port) begin
        verdict_next = mlfd_pkg::VERDICT_FILTER;
      end else begin
        verdict_next = mlfd_pkg::VERDICT_FORWARD;
        egress_next  = lookup.dst_port;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      verdict      <= verdict_next;
      egress_port  <= egress_next;
      learn_failed <= failed_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mlfd_table.sv */
// Address table of the learning bridge: valid bits, addresses and ports in
// flip-flops, parallel compare on source and destination, learning write.
// Depends on mlfd_pkg.
`default_nettype none

module mlfd_table (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [mlfd_pkg::ADDR_W-1:0]   src,
  input  wire logic [mlfd_pkg::ADDR_W-1:0]   dst,
  input  wire logic [mlfd_pkg::PORT_W-1:0]   port,
  input  wire logic                          learn,
  output mlfd_pkg::lookup_t                  lookup
);

  localparam int N = mlfd_pkg::TABLE_ENTRIES;

  logic [N-1:0]                        entry_valid;
  logic [mlfd_pkg::ADDR_W-1:0]         entry_address [N];
  logic [mlfd_pkg::PORT_W-1:0]         entry_port    [N];

  logic [N-1:0]                        src_hit;
  logic [N-1:0]                        dst_hit;
  logic [N-1:0]                        free_first;
  logic [N-1:0]                        port_wr;
  logic [N-1:0]                        addr_wr;
  logic                                src_any;
  logic [mlfd_pkg::PORT_W-1:0]         dst_port;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      src_hit[i] = entry_valid[i] && (entry_address[i] == src);
      dst_hit[i] = entry_valid[i] && (entry_address[i] == dst);
    end
  end

  // Lowest clear valid bit, one-hot.
  assign free_first = ~entry_valid & (entry_valid + N'(1));
  assign src_any    = |src_hit;

  assign addr_wr = src_any ? '0 : free_first;
  assign port_wr = src_hit | addr_wr;

  // Entries never duplicate, so at most one destination hit.
  always_comb begin
    dst_port = '0;
    for (int i = 0; i < N; i++) begin
      dst_port = dst_port | (dst_hit[i] ? entry_port[i] : '0);
    end
  end

  assign lookup.src_stored = src_any || (|free_first);
  assign lookup.dst_hit    = |dst_hit;
  assign lookup.dst_port   = dst_port;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (learn) begin
      entry_valid <= entry_valid | addr_wr;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (learn && addr_wr[i]) begin
        entry_address[i] <= src;
      end
      if (learn && port_wr[i]) begin
        entry_port[i] <= port;
      end
    end
  end

endmodule

`default_nettype wire
